@@ src/owtr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_pkg
// Shared types and constants for the one-wire temperature sensor reader.
// ---------------------------------------------------------------------------
package owtr_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_TAIL    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_START    = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_TAIL     = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_HOLD    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY      = 4'd7;

  // Register reset values (ticks)
  localparam logic [15:0] RST_RESET_LOW     = 16'd3860;
  localparam logic [15:0] RST_PRESENCE_WAIT = 16'd576;
  localparam logic [15:0] RST_RESET_TAIL    = 16'd3400;
  localparam logic [15:0] RST_SLOT_START    = 16'd8;
  localparam logic [15:0] RST_READ_SAMPLE   = 16'd104;
  localparam logic [15:0] RST_READ_TAIL     = 16'd680;
  localparam logic [15:0] RST_WRITE_HOLD    = 16'd520;
  localparam logic [15:0] RST_RECOVERY      = 16'd24;

  // Parameter defaults
  localparam int RESET_TRIES_DEF   = 3;
  localparam int SCRATCH_BYTES_DEF = 9;

  // Bus commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // Dallas CRC-8, reflected polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_PRESENCE = 2'd1;
  localparam logic [1:0] STATUS_NO_PRES_CNV = 2'd2;
  localparam logic [1:0] STATUS_CRC_ERROR   = 2'd3;

  // Phase lengths from the register file
  typedef struct packed {
    logic [15:0] reset_low;
    logic [15:0] presence_wait;
    logic [15:0] reset_tail;
    logic [15:0] slot_start;
    logic [15:0] read_sample;
    logic [15:0] read_tail;
    logic [15:0] write_hold;
    logic [15:0] recovery;
  } timing_t;

  // One result beat
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
  } result_t;

endpackage

@@ src/owtr_tick_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_tick_if
// Input channel: one beat per bus tick with start request and line level.
// ---------------------------------------------------------------------------
interface owtr_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_in;

  modport source (output valid, output start_req, output line_in, input ready);
  modport sink   (input valid, input start_req, input line_in, output ready);
endinterface

@@ src/owtr_result_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_result_if
// Result channel: one beat per accepted tick.
// ---------------------------------------------------------------------------
interface owtr_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [3:0] byte_index;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output status, output byte_valid, output byte_value,
                  output byte_index, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input status, input byte_valid, input byte_value,
                  input byte_index, output ready);
endinterface

@@ src/owtr_cfg_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface owtr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [owtr_pkg::CFG_INDEX_W-1:0] index;
  logic [owtr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/owtr_cfg_regs.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_cfg_regs
// Timing register file; writes outside the register list are dropped.
// ---------------------------------------------------------------------------
module owtr_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  owtr_cfg_if.sink          cfg,
  output owtr_pkg::timing_t timing
);

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low     <= owtr_pkg::RST_RESET_LOW;
      timing.presence_wait <= owtr_pkg::RST_PRESENCE_WAIT;
      timing.reset_tail    <= owtr_pkg::RST_RESET_TAIL;
      timing.slot_start    <= owtr_pkg::RST_SLOT_START;
      timing.read_sample   <= owtr_pkg::RST_READ_SAMPLE;
      timing.read_tail     <= owtr_pkg::RST_READ_TAIL;
      timing.write_hold    <= owtr_pkg::RST_WRITE_HOLD;
      timing.recovery      <= owtr_pkg::RST_RECOVERY;
    end else if (cfg.valid) begin
      case (cfg.index)
        owtr_pkg::REG_RESET_LOW:     timing.reset_low     <= cfg.data;
        owtr_pkg::REG_PRESENCE_WAIT: timing.presence_wait <= cfg.data;
        owtr_pkg::REG_RESET_TAIL:    timing.reset_tail    <= cfg.data;
        owtr_pkg::REG_SLOT_START:    timing.slot_start    <= cfg.data;
        owtr_pkg::REG_READ_SAMPLE:   timing.read_sample   <= cfg.data;
        owtr_pkg::REG_READ_TAIL:     timing.read_tail     <= cfg.data;
        owtr_pkg::REG_WRITE_HOLD:    timing.write_hold    <= cfg.data;
        owtr_pkg::REG_RECOVERY:      timing.recovery      <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/owtr_crc8.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_crc8
// Folds one byte into the Dallas CRC-8 (reflected, LSB first).
// ---------------------------------------------------------------------------
module owtr_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  // Eight bit steps over the xor of crc and data
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ owtr_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

@@ src/owtr_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owtr_seq
// Bus sequencer: reset/presence, command writes, conversion wait and
// scratchpad reads. Advances one tick per accepted beat.
// ---------------------------------------------------------------------------
module owtr_seq #(
  parameter int RESET_TRIES   = owtr_pkg::RESET_TRIES_DEF,
  parameter int SCRATCH_BYTES = owtr_pkg::SCRATCH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              start_req,
  input  logic              line_in,
  input  owtr_pkg::timing_t timing,
  output owtr_pkg::result_t result
);

  localparam logic [1:0] TRIES_INIT = 2'(RESET_TRIES);
  localparam logic [3:0] BYTES_LAST = 4'(SCRATCH_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT_LOW,
    PH_WR_HOLD, PH_WR_REC, PH_RD_WAIT, PH_RD_TAIL, PH_CONV_WAIT
  } phase_t;

  typedef enum logic [3:0] {
    ST_RESET1, ST_SKIP1, ST_CONVERT, ST_CONV, ST_RESET2,
    ST_SKIP2, ST_READCMD, ST_READ, ST_FINAL
  } stage_t;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [15:0] tick_count, tick_next;
  logic [2:0]  bit_count, bit_next;
  logic [3:0]  byte_count, byte_next;
  logic [7:0]  shift_byte, shift_next;
  logic [7:0]  crc_value, crc_next;
  logic [1:0]  tries_left, tries_next;
  logic        present, present_next;

  logic [15:0] phase_len;
  logic        timed;
  logic        phase_end;
  logic [7:0]  shift_new;
  logic [7:0]  crc_fold;
  logic [7:0]  cmd_byte;
  logic [2:0]  bit_inc;
  logic [1:0]  tries_dec;

  // Length of the running phase
  always_comb begin
    timed     = 1'b1;
    phase_len = '0;
    case (phase)
      PH_RST_LOW:  phase_len = timing.reset_low;
      PH_RST_WAIT: phase_len = timing.presence_wait;
      PH_RST_TAIL: phase_len = timing.reset_tail;
      PH_SLOT_LOW: phase_len = timing.slot_start;
      PH_WR_HOLD:  phase_len = timing.write_hold;
      PH_WR_REC:   phase_len = timing.recovery;
      PH_RD_WAIT:  phase_len = timing.read_sample;
      PH_RD_TAIL:  phase_len = timing.read_tail;
      default:     timed = 1'b0;
    endcase
  end

  // Last tick of a phase; a zero length still lasts one tick
  assign phase_end = ({1'b0, tick_count} + 17'd1) >= {1'b0, phase_len};

  assign shift_new = {line_in, shift_byte[7:1]};
  assign bit_inc   = bit_count + 3'd1;
  assign tries_dec = tries_left - 2'd1;

  // Command for the current write stage
  always_comb begin
    case (stage)
      ST_SKIP1, ST_SKIP2: cmd_byte = owtr_pkg::CMD_SKIP_ROM;
      ST_CONVERT:         cmd_byte = owtr_pkg::CMD_CONVERT;
      default:            cmd_byte = owtr_pkg::CMD_READ_PAD;
    endcase
  end

  owtr_crc8 u_crc (
    .crc_in  (crc_value),
    .data    (shift_new),
    .crc_out (crc_fold)
  );

  // Next state and result of this tick
  always_comb begin
    phase_next   = phase;
    stage_next   = stage;
    tick_next    = tick_count;
    bit_next     = bit_count;
    byte_next    = byte_count;
    shift_next   = shift_byte;
    crc_next     = crc_value;
    tries_next   = tries_left;
    present_next = present;
    result          = '0;
    result.busy_res = 1'b1;

    // timed phases count up, and every phase change restarts the count
    if (timed) begin
      tick_next = phase_end ? 16'd0 : tick_count + 16'd1;
    end

    case (phase)
      PH_IDLE: begin
        result.busy_res = 1'b0;
        if (start_req) begin
          tries_next = TRIES_INIT;
          crc_next   = '0;
          byte_next  = '0;
          stage_next = ST_RESET1;
          bit_next   = '0;
          phase_next = PH_RST_LOW;
          tick_next  = '0;
        end
      end
      PH_RST_LOW: begin
        result.drive_low = 1'b1;
        if (phase_end) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (phase_end) begin
          present_next = ~line_in;
          phase_next   = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        if (phase_end) begin
          bit_next = '0;
          case (stage)
            ST_RESET1: begin
              if (present) begin
                stage_next = ST_SKIP1;
                phase_next = PH_SLOT_LOW;
              end else begin
                tries_next = tries_dec;
                if (tries_dec == 2'd0) begin
                  result.done_res = 1'b1;
                  result.status   = owtr_pkg::STATUS_NO_PRESENCE;
                  bit_next        = bit_count;
                  phase_next      = PH_IDLE;
                end else begin
                  phase_next = PH_RST_LOW;
                end
              end
            end
            ST_RESET2: begin
              if (present) begin
                stage_next = ST_SKIP2;
                phase_next = PH_SLOT_LOW;
              end else begin
                result.done_res = 1'b1;
                result.status   = owtr_pkg::STATUS_NO_PRES_CNV;
                bit_next        = bit_count;
                phase_next      = PH_IDLE;
              end
            end
            default: begin
              result.done_res = 1'b1;
              result.status   = (crc_value != 8'd0) ? owtr_pkg::STATUS_CRC_ERROR
                                                    : owtr_pkg::STATUS_OK;
              bit_next        = bit_count;
              phase_next      = PH_IDLE;
            end
          endcase
        end
      end
      PH_SLOT_LOW: begin
        result.drive_low = 1'b1;
        if (phase_end) phase_next = (stage == ST_READ) ? PH_RD_WAIT : PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        result.drive_low = ~cmd_byte[bit_count];
        if (phase_end) phase_next = PH_WR_REC;
      end
      PH_WR_REC: begin
        if (phase_end) begin
          bit_next = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_next = PH_SLOT_LOW;
          end else begin
            case (stage)
              ST_SKIP1: begin
                stage_next = ST_CONVERT;
                phase_next = PH_SLOT_LOW;
              end
              ST_CONVERT: begin
                stage_next = ST_CONV;
                phase_next = PH_CONV_WAIT;
              end
              ST_SKIP2: begin
                stage_next = ST_READCMD;
                phase_next = PH_SLOT_LOW;
              end
              default: begin
                byte_next  = '0;
                stage_next = ST_READ;
                phase_next = PH_SLOT_LOW;
              end
            endcase
          end
        end
      end
      PH_RD_WAIT: begin
        if (phase_end) begin
          shift_next = shift_new;
          // last bit of a byte: emit it and fold it into the crc
          if (bit_count == 3'd7) begin
            result.byte_valid = 1'b1;
            result.byte_value = shift_new;
            result.byte_index = byte_count;
            crc_next          = crc_fold;
            byte_next         = byte_count + 4'd1;
          end
          bit_next   = bit_inc;
          phase_next = PH_RD_TAIL;
        end
      end
      PH_RD_TAIL: begin
        if (phase_end) begin
          if (bit_count == 3'd0 && byte_count >= BYTES_LAST) begin
            stage_next = ST_FINAL;
            phase_next = PH_RST_LOW;
          end else begin
            phase_next = PH_SLOT_LOW;
          end
        end
      end
      PH_CONV_WAIT: begin
        if (line_in) begin
          crc_next   = '0;
          stage_next = ST_RESET2;
          bit_next   = '0;
          phase_next = PH_RST_LOW;
          tick_next  = '0;
        end
      end
      default: begin
        result.busy_res = 1'b0;
        phase_next      = PH_IDLE;
        tick_next       = '0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      stage      <= ST_RESET1;
      tick_count <= '0;
      bit_count  <= '0;
      byte_count <= '0;
      shift_byte <= '0;
      crc_value  <= '0;
      tries_left <= TRIES_INIT;
      present    <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      stage      <= stage_next;
      tick_count <= tick_next;
      bit_count  <= bit_next;
      byte_count <= byte_next;
      shift_byte <= shift_next;
      crc_value  <= crc_next;
      tries_left <= tries_next;
      present    <= present_next;
    end
  end

endmodule

@@ src/onewire_temp_sensor_reader.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// onewire_temp_sensor_reader
// One-wire master that reads a sensor scratchpad, one bus tick per beat.
// ---------------------------------------------------------------------------
// The result beat of an accepted tick beat is registered for the next cycle.
// Throughput: 1 beat per cycle unless stalled; sequencer steps once a beat.
// The result register frees the input whenever it is empty or being taken.
// Reset: sequencer idle, counters and crc cleared, retry count full,
// timing registers at their defaults; no clearing pass.
module onewire_temp_sensor_reader #(
  parameter int RESET_TRIES   = owtr_pkg::RESET_TRIES_DEF,
  parameter int SCRATCH_BYTES = owtr_pkg::SCRATCH_BYTES_DEF
) (
  input logic           clk,
  input logic           rst,
  owtr_tick_if.sink     tick,
  owtr_result_if.source result,
  owtr_cfg_if.sink      cfg
);

  owtr_pkg::timing_t timing;
  owtr_pkg::result_t res_comb;
  owtr_pkg::result_t res_reg;
  logic              res_valid;
  logic              step;

  owtr_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .timing (timing)
  );

  // Accept a tick when the result register is empty or draining
  assign tick.ready = ~res_valid | result.ready;
  assign step       = tick.valid & tick.ready;

  owtr_seq #(
    .RESET_TRIES   (RESET_TRIES),
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (tick.start_req),
    .line_in   (tick.line_in),
    .timing    (timing),
    .result    (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (step) begin
      res_reg <= res_comb;
    end
  end

  assign result.valid      = res_valid;
  assign result.drive_low  = res_reg.drive_low;
  assign result.busy_res   = res_reg.busy_res;
  assign result.done_res   = res_reg.done_res;
  assign result.status     = res_reg.status;
  assign result.byte_valid = res_reg.byte_valid;
  assign result.byte_value = res_reg.byte_value;
  assign result.byte_index = res_reg.byte_index;

  // A finished sequence is still reported as busy on its last tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg.done_res |-> res_reg.busy_res)
    else $error("done beat without busy");

  // Status is only meaningful on the done beat
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_reg.done_res |-> res_reg.status == owtr_pkg::STATUS_OK)
    else $error("status set outside done beat");

  // Scratchpad bytes stay within the configured count
  a_byte_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg.byte_valid |-> res_reg.byte_index < 4'(SCRATCH_BYTES))
    else $error("byte index beyond scratchpad");

  // No byte or done beat while the bus is driven low
  a_byte_drive: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_reg.byte_valid || res_reg.done_res) |-> !res_reg.drive_low)
    else $error("byte or done beat while driving low");

endmodule
